// ----- hw/rtl/i2cms_pkg.sv -----
package i2cms_pkg;

  localparam int WRITE_DEPTH = 16;
  localparam int READ_DEPTH  = 16;
  localparam int WR_AW       = $clog2(WRITE_DEPTH);

  localparam int ADDR_W   = 7;
  localparam int COUNT_W  = 5;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 7;
  localparam int BYTE_W   = 8;
  localparam int SLOT_W   = 4;
  localparam int BITC_W   = 4;
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = $clog2(Q_DEPTH);

  localparam logic [COUNT_W-1:0] WCOUNT_MAX = COUNT_W'(WRITE_DEPTH);
  localparam logic [COUNT_W-1:0] RCOUNT_MAX = COUNT_W'(READ_DEPTH);
  localparam logic [BITC_W-1:0]  BITS_PER_BYTE = BITC_W'(8);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_START = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_BUSY = 2'd1,
    ST_DONE = 2'd2,
    ST_FAIL = 2'd3
  } status_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_DEV_ADDR = 2'd0,
    CFG_WR_COUNT = 2'd1,
    CFG_RD_COUNT = 2'd2
  } cfg_idx_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_DONE, PH_FAIL,
    PH_WSTART, PH_WADDR, PH_WABIT, PH_WALOW, PH_WAREL, PH_WACHK,
    PH_WDLOAD, PH_WDBIT, PH_WDLOW, PH_WDREL, PH_WDCHK,
    PH_WSTOP1, PH_WSTOP2, PH_RSTART,
    PH_RADDR, PH_RABIT, PH_RALOW, PH_RAREL, PH_RACHK,
    PH_RBYTE, PH_RREL, PH_RBHI, PH_RBSAMP, PH_RBACK,
    PH_RSTOP1, PH_RSTOP2, PH_REND
  } phase_t;

  typedef struct packed {
    logic              sda_release;
    logic              scl_release;
    logic [1:0]        status;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_read;
    logic [SLOT_W-1:0] byte_slot;
    logic              last_update;
  } res_t;

  // results of one accepted item, first one in r0
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// ----- hw/rtl/i2c_master_write_read_sequencer_unit.sv -----
// A tick's results are written into the registered result queue when the tick is accepted.
// Throughput: one item per cycle; a tick gives one or two results and the
// four-entry result queue stalls input once fewer than two entries are free.
// The write store is a 16x8 single-port-read RAM, read ahead from the next byte position.
// Reset (rst_n low, synchronous): idle, both lines released, control registers zero;
// the write store keeps its contents and is undefined until loaded.
module i2c_master_write_read_sequencer_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_command,
  input  logic [3:0]                   in_load_index,
  input  logic [7:0]                   in_load_byte,
  input  logic                         in_sda_sampled,
  input  logic                         in_scl_sampled,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_sda_release,
  output logic                         out_scl_release,
  output logic [1:0]                   out_status,
  output logic                         out_byte_valid,
  output logic [7:0]                   out_byte_read,
  output logic [3:0]                   out_byte_slot,
  output logic                         out_last_update,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [i2cms_pkg::CFG_IW-1:0] cfg_index,
  input  logic [i2cms_pkg::CFG_DW-1:0] cfg_data
);
  import i2cms_pkg::*;

  push_t push;
  res_t  head;
  logic  q_full, accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  i2cms_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .command     (in_command),
    .load_index  (in_load_index),
    .load_byte   (in_load_byte),
    .sda_sampled (in_sda_sampled),
    .scl_sampled (in_scl_sampled),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push)
  );

  i2cms_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_valid && !out_stall),
    .full      (q_full),
    .not_empty (out_valid),
    .head      (head)
  );

  assign out_sda_release = head.sda_release;
  assign out_scl_release = head.scl_release;
  assign out_status      = head.status;
  assign out_byte_valid  = head.byte_valid;
  assign out_byte_read   = head.byte_read;
  assign out_byte_slot   = head.byte_slot;
  assign out_last_update = head.last_update;

endmodule

// ----- hw/rtl/i2cms_ram.sv -----
module i2cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/i2cms_seq.sv -----
module i2cms_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [1:0]                    command,
  input  logic [3:0]                    load_index,
  input  logic [7:0]                    load_byte,
  input  logic                          sda_sampled,
  input  logic                          scl_sampled,
  input  logic                          cfg_we,
  input  logic [i2cms_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [i2cms_pkg::CFG_DW-1:0]  cfg_data,
  output i2cms_pkg::push_t              push
);
  import i2cms_pkg::*;

  logic [ADDR_W-1:0]  dev_r;
  logic [COUNT_W-1:0] wcfg_r, rcfg_r, wc, rc;

  phase_t             phase_r, ph_nxt;
  logic [BITC_W-1:0]  bc_r, bc_nxt, bc_inc;
  logic [COUNT_W-1:0] bp_r, bp_nxt, bp_inc;
  logic [BYTE_W-1:0]  sr_r, sr_nxt, sr_sh, wr_byte, ram_rdata, byp_data_r;
  logic               sda_r, scl_r, sda_nxt, scl_nxt;
  logic               byp_hit_r;
  logic               load_we, is_tick, busy, step;
  logic [1:0]         n_upd, u0, u1, lvl;
  logic               rd_valid;
  logic [1:0]         st;
  res_t               r_a, r_b;

  assign load_we = accept && (command == CMD_LOAD);
  assign is_tick = accept && (command == CMD_TICK);
  assign busy    = (phase_r != PH_IDLE) && (phase_r != PH_DONE) && (phase_r != PH_FAIL);
  assign step    = is_tick && busy && !(scl_r && !scl_sampled);

  assign wc = (wcfg_r > WCOUNT_MAX) ? WCOUNT_MAX : wcfg_r;
  assign rc = (rcfg_r > RCOUNT_MAX) ? RCOUNT_MAX : rcfg_r;

  assign bc_inc = bc_r + BITC_W'(1);
  assign bp_inc = bp_r + COUNT_W'(1);
  assign sr_sh  = {sr_r[BYTE_W-2:0], 1'b0};

  // write store; read address follows the next byte position so the byte is
  // ready on the following cycle, with a bypass for a load to the same slot
  i2cms_ram #(.WIDTH(BYTE_W), .DEPTH(WRITE_DEPTH)) u_store (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_index[WR_AW-1:0]),
    .wdata (load_byte),
    .raddr (bp_nxt[WR_AW-1:0]),
    .rdata (ram_rdata)
  );

  assign wr_byte = byp_hit_r ? byp_data_r : ram_rdata;

  always_comb begin
    ph_nxt   = phase_r;
    bc_nxt   = bc_r;
    bp_nxt   = bp_r;
    sr_nxt   = sr_r;
    n_upd    = 2'd0;
    u0       = {sda_r, scl_r};
    u1       = {sda_r, scl_r};
    rd_valid = 1'b0;
    if (accept && (command == CMD_START)) begin
      ph_nxt = PH_WSTART;
    end else if (step) begin
      unique case (phase_r)
        PH_WSTART, PH_RSTART: begin
          if ((phase_r == PH_WSTART) && (wc != '0)) begin
            u0 = {1'b0, scl_r}; u1 = 2'b00; n_upd = 2'd2;
            bp_nxt = '0;
            ph_nxt = PH_WADDR;
          end else if (rc == '0) begin
            ph_nxt = PH_DONE;
          end else begin
            u0 = {1'b0, scl_r}; u1 = 2'b00; n_upd = 2'd2;
            bp_nxt = '0;
            ph_nxt = PH_RADDR;
          end
        end
        PH_WADDR, PH_RADDR, PH_WDLOAD: begin
          if (phase_r == PH_WDLOAD) sr_nxt = wr_byte;
          else sr_nxt = {dev_r, phase_r == PH_RADDR};
          bc_nxt = '0;
          u0 = {sr_nxt[BYTE_W-1], scl_r}; u1 = {sr_nxt[BYTE_W-1], 1'b1}; n_upd = 2'd2;
          ph_nxt = (phase_r == PH_WADDR) ? PH_WALOW :
                   (phase_r == PH_RADDR) ? PH_RALOW : PH_WDLOW;
        end
        PH_WABIT, PH_RABIT, PH_WDBIT: begin
          u0 = {sr_r[BYTE_W-1], scl_r}; u1 = {sr_r[BYTE_W-1], 1'b1}; n_upd = 2'd2;
          ph_nxt = (phase_r == PH_WABIT) ? PH_WALOW :
                   (phase_r == PH_RABIT) ? PH_RALOW : PH_WDLOW;
        end
        PH_WALOW, PH_RALOW, PH_WDLOW: begin
          sr_nxt = sr_sh;
          bc_nxt = bc_inc;
          u0 = {sda_r, 1'b0}; n_upd = 2'd1;
          if (bc_inc >= BITS_PER_BYTE) begin
            ph_nxt = (phase_r == PH_WALOW) ? PH_WAREL :
                     (phase_r == PH_RALOW) ? PH_RAREL : PH_WDREL;
          end else begin
            ph_nxt = (phase_r == PH_WALOW) ? PH_WABIT :
                     (phase_r == PH_RALOW) ? PH_RABIT : PH_WDBIT;
          end
        end
        PH_WAREL, PH_RAREL, PH_WDREL, PH_RSTOP2: begin
          u0 = (phase_r == PH_RSTOP2) ? {sda_r, 1'b1} : {1'b1, scl_r};
          u1 = 2'b11; n_upd = 2'd2;
          ph_nxt = (phase_r == PH_WAREL) ? PH_WACHK :
                   (phase_r == PH_RAREL) ? PH_RACHK :
                   (phase_r == PH_WDREL) ? PH_WDCHK : PH_REND;
        end
        PH_WACHK: begin
          u0 = {sda_r, 1'b0}; n_upd = 2'd1;
          ph_nxt = sda_sampled ? PH_WSTOP1 : PH_WDLOAD;
        end
        PH_WDCHK: begin
          bp_nxt = bp_inc;
          u0 = {sda_r, 1'b0}; n_upd = 2'd1;
          ph_nxt = (!sda_sampled && (bp_inc < wc)) ? PH_WDLOAD : PH_WSTOP1;
        end
        PH_WSTOP1: begin
          u0 = {1'b0, scl_r}; n_upd = 2'd1;
          ph_nxt = PH_WSTOP2;
        end
        PH_WSTOP2: begin
          u0 = {sda_r, 1'b1}; u1 = 2'b11; n_upd = 2'd2;
          if (bp_r != wc) ph_nxt = PH_FAIL;
          else if (rc == '0) ph_nxt = PH_DONE;
          else ph_nxt = PH_RSTART;
        end
        PH_RACHK, PH_RBYTE: begin
          if ((phase_r == PH_RACHK) && sda_sampled) begin
            u0 = {sda_r, 1'b0}; u1 = 2'b00; n_upd = 2'd2;
            ph_nxt = PH_RSTOP2;
          end else begin
            if (phase_r == PH_RACHK) bp_nxt = '0;
            sr_nxt = '0;
            bc_nxt = '0;
            u0 = {sda_r, 1'b0}; n_upd = 2'd1;
            ph_nxt = PH_RREL;
          end
        end
        PH_RREL: begin
          sr_nxt = sr_sh;
          u0 = {1'b1, scl_r}; u1 = 2'b11; n_upd = 2'd2;
          ph_nxt = PH_RBSAMP;
        end
        PH_RBHI: begin
          sr_nxt = sr_sh;
          u0 = {sda_r, 1'b1}; n_upd = 2'd1;
          ph_nxt = PH_RBSAMP;
        end
        PH_RBSAMP: begin
          sr_nxt = {sr_r[BYTE_W-1:1], sda_sampled};
          bc_nxt = bc_inc;
          u0 = {sda_r, 1'b0}; n_upd = 2'd1;
          ph_nxt = (bc_inc < BITS_PER_BYTE) ? PH_RBHI : PH_RBACK;
        end
        PH_RBACK: begin
          bp_nxt = bp_inc;
          rd_valid = 1'b1;
          // NACK the last byte, ACK the others
          if (bp_inc >= rc) begin
            u0 = {1'b1, scl_r}; u1 = 2'b11;
            ph_nxt = PH_RSTOP1;
          end else begin
            u0 = {1'b0, scl_r}; u1 = 2'b01;
            ph_nxt = PH_RBYTE;
          end
          n_upd = 2'd2;
        end
        PH_RSTOP1: begin
          u0 = {sda_r, 1'b0}; u1 = 2'b00; n_upd = 2'd2;
          ph_nxt = PH_RSTOP2;
        end
        PH_REND: begin
          ph_nxt = (bp_r == rc) ? PH_DONE : PH_FAIL;
        end
        default: begin
          ph_nxt = phase_r;
        end
      endcase
    end
  end

  assign lvl     = (n_upd == 2'd2) ? u1 : u0;
  assign sda_nxt = (n_upd == 2'd0) ? sda_r : lvl[1];
  assign scl_nxt = (n_upd == 2'd0) ? scl_r : lvl[0];

  always_comb begin
    unique case (ph_nxt)
      PH_IDLE: st = ST_IDLE;
      PH_DONE: st = ST_DONE;
      PH_FAIL: st = ST_FAIL;
      default: st = ST_BUSY;
    endcase
  end

  // the last result of the tick carries the byte report
  always_comb begin
    r_a             = '0;
    r_a.sda_release = u0[1];
    r_a.scl_release = u0[0];
    r_a.status      = st;
    r_b             = r_a;
    r_b.sda_release = u1[1];
    r_b.scl_release = u1[0];
    r_b.byte_valid  = rd_valid;
    r_b.byte_read   = rd_valid ? sr_r : '0;
    r_b.byte_slot   = rd_valid ? bp_r[SLOT_W-1:0] : '0;
    r_b.last_update = 1'b1;
    push = '0;
    if (is_tick) begin
      if (n_upd == 2'd2) begin
        push.cnt = 2'd2;
        push.r0  = r_a;
        push.r1  = r_b;
      end else begin
        push.cnt = 2'd1;
        push.r0  = r_b;
        if (n_upd == 2'd0) begin
          push.r0.sda_release = sda_r;
          push.r0.scl_release = scl_r;
        end else begin
          push.r0.sda_release = u0[1];
          push.r0.scl_release = u0[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r     <= '0;
      wcfg_r    <= '0;
      rcfg_r    <= '0;
      phase_r   <= PH_IDLE;
      bc_r      <= '0;
      bp_r      <= '0;
      sr_r      <= '0;
      sda_r     <= 1'b1;
      scl_r     <= 1'b1;
      byp_hit_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DEV_ADDR: dev_r  <= cfg_data;
          CFG_WR_COUNT: wcfg_r <= cfg_data[COUNT_W-1:0];
          CFG_RD_COUNT: rcfg_r <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      phase_r   <= ph_nxt;
      bc_r      <= bc_nxt;
      bp_r      <= bp_nxt;
      sr_r      <= sr_nxt;
      sda_r     <= sda_nxt;
      scl_r     <= scl_nxt;
      byp_hit_r <= load_we && (load_index[WR_AW-1:0] == bp_nxt[WR_AW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= load_byte;
  end

endmodule

// ----- hw/rtl/i2cms_outq.sv -----
module i2cms_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  i2cms_pkg::push_t push,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output i2cms_pkg::res_t  head
);
  import i2cms_pkg::*;

  res_t            ent_r [Q_DEPTH];
  logic [Q_AW-1:0] rd_r, wr_r, wr_plus;
  logic [Q_AW:0]   cnt_r;

  assign wr_plus   = wr_r + Q_AW'(1);
  assign not_empty = (cnt_r != '0);
  // hold input while fewer than two entries are free
  assign full      = (cnt_r > (Q_AW + 1)'(Q_DEPTH - 2));
  assign head      = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      ent_r[wr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      ent_r[wr_plus] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= '0;
      wr_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + Q_AW'(push.cnt);
      rd_r  <= rd_r + Q_AW'(pop);
      cnt_r <= cnt_r + (Q_AW + 1)'(push.cnt) - (Q_AW + 1)'(pop);
    end
  end

endmodule
